// ===== rtl/ltfd_pkg.sv =====
// ----------------------------------------------------------------------------
// ltfd_pkg: shared types and constants of the LED track frame decoder
// Table sizes, field widths and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package ltfd_pkg;

  localparam int MAX_TRACKS = 16;
  localparam int MSG_LEN    = 32;

  localparam int SLOT_W  = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int COUNT_W = $clog2(MAX_TRACKS + 1);
  localparam int IDX_W   = (MSG_LEN > 1) ? $clog2(MSG_LEN) : 1;
  localparam int LEN_W   = $clog2(MSG_LEN + 1);
  localparam int TBL_AW  = $clog2(2 * MAX_TRACKS);
  localparam int MEM_DEPTH = 2 * MAX_TRACKS * MSG_LEN;
  localparam int MEM_AW  = $clog2(MEM_DEPTH);

  localparam int THR_W   = 25;
  localparam logic [THR_W-1:0] THR_RESET = 25'd160000;

  localparam logic [6:0] SYM_HEADER = 7'd2;
  localparam logic [6:0] SYM_FOOTER = 7'd3;

  typedef enum logic [1:0] {
    ST_IDLE      = 2'd0,
    ST_INPUTTING = 2'd1,
    ST_UPDATING  = 2'd2,
    ST_END       = 2'd3
  } link_t;

  typedef struct packed {
    logic [15:0]      age;
    link_t            status;
    logic [7:0]       code;
    logic [LEN_W-1:0] len;
    logic             ovf;
  } info_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SEARCH, S_DRAIN, S_INFO, S_RESOLVE, S_COPY, S_CDRAIN,
    S_STORE, S_REPORT, S_BRD, S_BOUT
  } state_t;

  typedef struct packed {
    logic              load;
    logic              swap;
    logic              search_rd;
    logic [SLOT_W-1:0] search_idx;
    logic              info_rd;
    logic              resolve;
    logic              copy_rd;
    logic              byte_rd;
    logic [IDX_W-1:0]  byte_idx;
    logic              store;
    logic              emit_byte;
  } cmd_t;

  typedef struct packed {
    logic               busy;
    logic [COUNT_W-1:0] prev_count;
    logic               full;
    logic               footer;
    logic [LEN_W-1:0]   copy_len;
    logic [LEN_W-1:0]   msg_len;
    logic               frame_end;
  } status_t;

endpackage

// ===== rtl/ltfd_ctrl.sv =====
// ----------------------------------------------------------------------------
// ltfd_ctrl: item sequencer
// Steps one item through search, fetch, copy, store and reporting.
// ----------------------------------------------------------------------------
module ltfd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               point_valid,
  input  logic               frame_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               last,
  output ltfd_pkg::cmd_t     cmd,
  input  ltfd_pkg::status_t  stat
);

  ltfd_pkg::state_t state, state_next;
  logic [ltfd_pkg::COUNT_W-1:0] j, j_next;
  logic [ltfd_pkg::LEN_W-1:0]   k, k_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ltfd_pkg::S_IDLE;
      j     <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      j     <= j_next;
      k     <= k_next;
    end
  end

  always_comb begin
    state_next     = state;
    j_next         = j;
    k_next         = k;
    cmd            = '0;
    cmd.search_idx = j[ltfd_pkg::SLOT_W-1:0];
    cmd.byte_idx   = k[ltfd_pkg::IDX_W-1:0];
    in_stall       = (state != ltfd_pkg::S_IDLE);
    out_valid      = 1'b0;
    last           = 1'b0;
    unique case (state)
      ltfd_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (point_valid) begin
            j_next     = '0;
            state_next = ltfd_pkg::S_SEARCH;
          end else begin
            cmd.swap = frame_end;
          end
        end
      end
      ltfd_pkg::S_SEARCH: begin
        if (j < stat.prev_count && j < ltfd_pkg::COUNT_W'(ltfd_pkg::MAX_TRACKS)) begin
          cmd.search_rd = 1'b1;
          j_next        = j + 1'b1;
        end else begin
          state_next = ltfd_pkg::S_DRAIN;
        end
      end
      ltfd_pkg::S_DRAIN: begin
        if (!stat.busy) state_next = ltfd_pkg::S_INFO;
      end
      ltfd_pkg::S_INFO: begin
        cmd.info_rd = 1'b1;
        state_next  = ltfd_pkg::S_RESOLVE;
      end
      ltfd_pkg::S_RESOLVE: begin
        cmd.resolve = 1'b1;
        k_next      = '0;
        state_next  = ltfd_pkg::S_COPY;
      end
      ltfd_pkg::S_COPY: begin
        if (!stat.full && k < stat.copy_len) begin
          cmd.copy_rd  = 1'b1;
          k_next       = k + 1'b1;
        end else begin
          state_next = ltfd_pkg::S_CDRAIN;
        end
      end
      ltfd_pkg::S_CDRAIN: begin
        if (!stat.busy) state_next = ltfd_pkg::S_STORE;
      end
      ltfd_pkg::S_STORE: begin
        cmd.store  = 1'b1;
        state_next = ltfd_pkg::S_REPORT;
      end
      ltfd_pkg::S_REPORT: begin
        out_valid = 1'b1;
        last      = !(stat.footer && stat.msg_len != '0);
        if (!out_stall) begin
          k_next = '0;
          if (last) begin
            cmd.swap   = stat.frame_end;
            state_next = ltfd_pkg::S_IDLE;
          end else begin
            state_next = ltfd_pkg::S_BRD;
          end
        end
      end
      ltfd_pkg::S_BRD: begin
        cmd.byte_rd = 1'b1;
        state_next  = ltfd_pkg::S_BOUT;
      end
      ltfd_pkg::S_BOUT: begin
        out_valid     = 1'b1;
        cmd.emit_byte = 1'b1;
        last          = (k + 1'b1 == stat.msg_len);
        if (!out_stall) begin
          k_next = k + 1'b1;
          if (last) begin
            cmd.swap   = stat.frame_end;
            state_next = ltfd_pkg::S_IDLE;
          end else begin
            state_next = ltfd_pkg::S_BRD;
          end
        end
      end
      default: state_next = ltfd_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== rtl/ltfd_datapath.sv =====
// ----------------------------------------------------------------------------
// ltfd_datapath: track tables, message store and distance search
// Two banks of every table; frame end swaps which bank is the previous one.
// ----------------------------------------------------------------------------
module ltfd_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  input  logic [ltfd_pkg::THR_W-1:0] cfg_data,
  input  logic [11:0]                pos_x,
  input  logic [11:0]                pos_y,
  input  logic [7:0]                 code_byte,
  input  logic                       frame_end,
  input  ltfd_pkg::cmd_t             cmd,
  output ltfd_pkg::status_t          stat,
  output logic                       report_kind,
  output logic [3:0]                 track_slot,
  output logic                       was_matched,
  output logic [1:0]                 link_status,
  output logic [15:0]                track_age,
  output logic [6:0]                 message_byte,
  output logic                       overflow_flag
);

  localparam int SW = ltfd_pkg::SLOT_W;
  localparam int IW = ltfd_pkg::IDX_W;
  localparam int LW = ltfd_pkg::LEN_W;

  logic [ltfd_pkg::THR_W-1:0] thr;
  logic                       bank;
  logic [ltfd_pkg::COUNT_W-1:0] prev_count, next_count;
  logic [11:0] x, y;
  logic [7:0]  code;
  logic        fe;

  logic [23:0]           pos_mem  [2*ltfd_pkg::MAX_TRACKS];
  ltfd_pkg::info_t       info_mem [2*ltfd_pkg::MAX_TRACKS];
  logic [6:0]            msg_mem  [ltfd_pkg::MEM_DEPTH];

  function automatic logic [ltfd_pkg::TBL_AW-1:0] tbl_addr(logic b, logic [SW-1:0] s);
    return ltfd_pkg::TBL_AW'(32'(b) * ltfd_pkg::MAX_TRACKS + 32'(s));
  endfunction

  function automatic logic [ltfd_pkg::MEM_AW-1:0] msg_addr(logic b, logic [SW-1:0] s,
                                                           logic [IW-1:0] i);
    return ltfd_pkg::MEM_AW'((32'(b) * ltfd_pkg::MAX_TRACKS + 32'(s)) * ltfd_pkg::MSG_LEN
                             + 32'(i));
  endfunction

  // search pipe
  logic          s1_v, s2_v;
  logic [SW-1:0] s1_idx, s2_idx;
  logic [23:0]   pos_rd;
  logic [24:0]   d2_q, d2;
  logic [11:0]   dx, dy;
  logic [24:0]   best;
  logic [SW-1:0] found;
  logic          found_v;

  always_comb begin
    dx = (x > pos_rd[11:0])  ? x - pos_rd[11:0]  : pos_rd[11:0]  - x;
    dy = (y > pos_rd[23:12]) ? y - pos_rd[23:12] : pos_rd[23:12] - y;
    d2 = 25'(24'(dx) * 24'(dx)) + 25'(24'(dy) * 24'(dy));
  end

  // resolve
  ltfd_pkg::info_t info_q;
  logic [15:0]     age_c;
  ltfd_pkg::link_t st_c, st_n;
  logic [7:0]      oc_c;
  logic [LW-1:0]   len_c, len_n, copy_c;
  logic            ovf_c, ovf_n, foot_n, app_n, rx;

  always_comb begin
    if (found_v) begin
      age_c = (info_q.age != 16'hFFFF) ? info_q.age + 16'd1 : info_q.age;
      st_c  = info_q.status;
      oc_c  = info_q.code;
      len_c = (info_q.len > LW'(ltfd_pkg::MSG_LEN)) ? LW'(ltfd_pkg::MSG_LEN) : info_q.len;
      ovf_c = info_q.ovf;
    end else begin
      age_c = '0;
      st_c  = ltfd_pkg::ST_IDLE;
      oc_c  = code;
      len_c = '0;
      ovf_c = 1'b0;
    end
    st_n   = st_c;
    len_n  = len_c;
    ovf_n  = ovf_c;
    foot_n = 1'b0;
    app_n  = 1'b0;
    copy_c = len_c;
    rx     = (st_c == ltfd_pkg::ST_INPUTTING) || (st_c == ltfd_pkg::ST_UPDATING);
    if (oc_c[7] != code[7]) begin
      if (code[6:0] == ltfd_pkg::SYM_HEADER) begin
        st_n   = (st_c == ltfd_pkg::ST_END) ? ltfd_pkg::ST_UPDATING : ltfd_pkg::ST_INPUTTING;
        len_n  = '0;
        ovf_n  = 1'b0;
        copy_c = '0;
      end else if (code[6:0] == ltfd_pkg::SYM_FOOTER && rx) begin
        st_n   = ltfd_pkg::ST_END;
        foot_n = 1'b1;
      end else if (rx) begin
        if (len_c < LW'(ltfd_pkg::MSG_LEN)) begin
          app_n = 1'b1;
          len_n = len_c + 1'b1;
        end else begin
          ovf_n = 1'b1;
        end
      end
    end
  end

  logic [15:0]     r_age;
  ltfd_pkg::link_t r_status;
  logic [LW-1:0]   r_len, r_copy;
  logic [IW-1:0]   r_app_idx;
  logic            r_ovf, r_foot, r_app, r_full, r_found;
  logic [SW-1:0]   r_slot;
  logic            full_c;

  assign full_c = (next_count >= ltfd_pkg::COUNT_W'(ltfd_pkg::MAX_TRACKS));

  // copy pipe
  logic          c_v;
  logic [IW-1:0] c_idx, copy_idx;
  logic [6:0]    mrd;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr        <= ltfd_pkg::THR_RESET;
      bank       <= 1'b0;
      prev_count <= '0;
      next_count <= '0;
      s1_v       <= 1'b0;
      s2_v       <= 1'b0;
      c_v        <= 1'b0;
      found_v    <= 1'b0;
      copy_idx   <= '0;
    end else begin
      if (cfg_valid) thr <= cfg_data;
      s1_v <= cmd.search_rd;
      s2_v <= s1_v;
      c_v  <= cmd.copy_rd;
      if (cmd.load) begin
        found_v <= 1'b0;
      end else if (s2_v && d2_q < best) begin
        found_v <= 1'b1;
      end
      if (cmd.resolve) copy_idx <= '0;
      else if (cmd.copy_rd) copy_idx <= copy_idx + 1'b1;
      if (cmd.store && !r_full) next_count <= next_count + 1'b1;
      if (cmd.swap) begin
        bank       <= ~bank;
        prev_count <= cmd.store && !r_full ? next_count + 1'b1 : next_count;
        next_count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x    <= pos_x;
      y    <= pos_y;
      code <= code_byte;
      fe   <= frame_end;
      best <= thr;
    end else if (s2_v && d2_q < best) begin
      best  <= d2_q;
      found <= s2_idx;
    end
    if (cmd.search_rd) begin
      pos_rd <= pos_mem[tbl_addr(bank, cmd.search_idx)];
      s1_idx <= cmd.search_idx;
    end
    d2_q   <= d2;
    s2_idx <= s1_idx;
    if (cmd.info_rd) info_q <= info_mem[tbl_addr(bank, found)];
    if (cmd.resolve) begin
      r_age     <= age_c;
      r_status  <= st_n;
      r_len     <= len_n;
      r_copy    <= copy_c;
      r_app_idx <= IW'(len_c);
      r_ovf     <= ovf_n;
      r_foot    <= foot_n;
      r_app     <= app_n;
      r_full    <= full_c;
      r_found   <= found_v;
      r_slot    <= full_c ? '0 : SW'(next_count);
    end
    if (cmd.copy_rd) begin
      mrd   <= msg_mem[msg_addr(bank, found, copy_idx)];
      c_idx <= copy_idx;
    end else if (cmd.byte_rd) begin
      mrd <= msg_mem[msg_addr(bank, found, cmd.byte_idx)];
    end
    if (c_v) begin
      msg_mem[msg_addr(~bank, r_slot, c_idx)] <= mrd;
    end else if (cmd.store && !r_full && r_app) begin
      msg_mem[msg_addr(~bank, r_slot, r_app_idx)] <= code[6:0];
    end
    if (cmd.store && !r_full) begin
      pos_mem[tbl_addr(~bank, r_slot)]  <= {y, x};
      info_mem[tbl_addr(~bank, r_slot)] <= '{age: r_age, status: r_status, code: code,
                                             len: r_len, ovf: r_ovf};
    end
  end

  always_comb begin
    stat            = '0;
    stat.busy       = s1_v | s2_v | c_v;
    stat.prev_count = prev_count;
    stat.full       = r_full;
    stat.footer     = r_foot;
    stat.copy_len   = r_copy;
    stat.msg_len    = r_len;
    stat.frame_end  = fe;
  end

  assign report_kind   = cmd.emit_byte;
  assign track_slot    = 4'(r_slot);
  assign was_matched   = r_found;
  assign link_status   = r_status;
  assign track_age     = r_age;
  assign message_byte  = cmd.emit_byte ? mrd : 7'd0;
  assign overflow_flag = cmd.emit_byte ? r_ovf : (r_ovf | r_full);

endmodule

// ===== rtl/led_track_frame_decoder_core.sv =====
// ----------------------------------------------------------------------------
// led_track_frame_decoder_core: LED point tracker and message decoder
// Matches each point to the previous frame's tracks and decodes toggled codes.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake             | Payload
// in      | sink      | in_valid / in_stall   | point_valid pos_x pos_y code_byte frame_end
// out     | source    | out_valid / out_stall | report_kind .. overflow_flag, last
// cfg     | sink      | cfg_valid / cfg_ready | cfg_data (match_threshold_sq)
//
// Flow: an item with a point runs the track search, one entry a cycle over
//   prev_count entries, then copies its message one byte a cycle through the
//   message memory before its report; each message byte of a footer is then
//   read (S_BRD) and output (S_BOUT), and an out stall holds it there.
// An item without a point is taken in S_IDLE; it swaps the banks if frame_end is set.
// Reset clears counts, bank select and control; tables hold garbage until written.
// in_stall is high while an item is in work; out stalls simply hold the result.
module led_track_frame_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        point_valid,
  input  logic [11:0] pos_x,
  input  logic [11:0] pos_y,
  input  logic [7:0]  code_byte,
  input  logic        frame_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        report_kind,
  output logic [3:0]  track_slot,
  output logic        was_matched,
  output logic [1:0]  link_status,
  output logic [15:0] track_age,
  output logic [6:0]  message_byte,
  output logic        overflow_flag,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [24:0] cfg_data
);

  ltfd_pkg::cmd_t    cmd;
  ltfd_pkg::status_t stat;

  // threshold writes must come only while idle; the block does not enforce this and always takes them
  assign cfg_ready = 1'b1;

  ltfd_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .point_valid (point_valid),
    .frame_end   (frame_end),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .last        (last),
    .cmd         (cmd),
    .stat        (stat)
  );

  ltfd_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .code_byte     (code_byte),
    .frame_end     (frame_end),
    .cmd           (cmd),
    .stat          (stat),
    .report_kind   (report_kind),
    .track_slot    (track_slot),
    .was_matched   (was_matched),
    .link_status   (link_status),
    .track_age     (track_age),
    .message_byte  (message_byte),
    .overflow_flag (overflow_flag)
  );

endmodule
